// ===== hdl/rorf_pkg.sv =====
// ----------------------------------------------------------------------------
// rorf_pkg
// Shared types and fixed constants of the rectangle outline/fill rasterizer.
// ----------------------------------------------------------------------------
package rorf_pkg;

  // Fixed field widths
  localparam int PIX_W   = 8;
  localparam int COORD_W = 24;
  localparam int SIDE_W  = 9;
  localparam int OP_W    = 2;
  localparam int RC_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // Register reset values
  localparam logic [SIDE_W-1:0] SIDE_RESET = 9'd1;
  localparam logic [PIX_W-1:0]  BG_RESET   = 8'd32;

  // Item operation codes
  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CANVAS_WIDTH  = 2'd0,
    REG_CANVAS_HEIGHT = 2'd1,
    REG_BACKGROUND    = 2'd2
  } cfg_reg_t;

endpackage

// ===== hdl/rorf_if.sv =====
// ----------------------------------------------------------------------------
// rorf_if
// Valid/ready channels for rasterizer items and results.
// ----------------------------------------------------------------------------
interface rorf_req_if import rorf_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           op;
  logic signed [COORD_W-1:0] rect_left;
  logic signed [COORD_W-1:0] rect_top;
  logic signed [COORD_W-1:0] rect_width;
  logic signed [COORD_W-1:0] rect_height;
  logic                      filled;
  logic [PIX_W-1:0]          fill_byte;
  logic [RC_W-1:0]           read_col;
  logic [RC_W-1:0]           read_row;

  modport source (output valid, op, rect_left, rect_top, rect_width, rect_height,
                  filled, fill_byte, read_col, read_row, input ready);
  modport sink   (input valid, op, rect_left, rect_top, rect_width, rect_height,
                  filled, fill_byte, read_col, read_row, output ready);
endinterface

interface rorf_rsp_if import rorf_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_byte;
  logic             error_flag;

  modport source (output valid, pixel_byte, error_flag, input ready);
  modport sink   (input valid, pixel_byte, error_flag, output ready);
endinterface

// ===== hdl/rorf_ram.sv =====
// ----------------------------------------------------------------------------
// rorf_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rorf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/rorf_span.sv =====
// ----------------------------------------------------------------------------
// rorf_span
// Pixel coverage test: decides whether pixel (col, row) takes the fill byte.
// ----------------------------------------------------------------------------
module rorf_span #(
  parameter int COL_W     = 8,
  parameter int FRAC_BITS = 8,
  parameter int SW        = 25
) (
  input  logic [COL_W-1:0]    col,
  input  logic [COL_W-1:0]    row,
  input  logic signed [SW-1:0] left,
  input  logic signed [SW-1:0] right,
  input  logic signed [SW-1:0] top,
  input  logic signed [SW-1:0] bottom,
  input  logic                 filled,
  output logic                 hit
);

  logic signed [SW-1:0] x;
  logic signed [SW-1:0] y;
  logic signed [SW-1:0] x_at;
  logic signed [SW-1:0] x_lo;
  logic signed [SW-1:0] x_hi;
  logic signed [SW-1:0] y_at;
  logic signed [SW-1:0] y_lo;
  logic signed [SW-1:0] y_hi;
  logic                 covered;
  logic                 on_edge;

  // Scale the pixel and its neighbors to fixed point
  always_comb begin
    x    = signed'(SW'(col));
    y    = signed'(SW'(row));
    x_at = x <<< FRAC_BITS;
    x_lo = (x - SW'(1)) <<< FRAC_BITS;
    x_hi = (x + SW'(1)) <<< FRAC_BITS;
    y_at = y <<< FRAC_BITS;
    y_lo = (y - SW'(1)) <<< FRAC_BITS;
    y_hi = (y + SW'(1)) <<< FRAC_BITS;
  end

  // Closed-rectangle test; an edge pixel is within one unit of a side
  assign covered = (x_at >= left) && (x_at <= right) && (y_at >= top) && (y_at <= bottom);
  assign on_edge = (x_lo < left) || (x_hi > right) || (y_lo < top) || (y_hi > bottom);
  assign hit     = covered && (on_edge || filled);

endmodule

// ===== hdl/rect_outline_fill_rasterizer_top.sv =====
// ----------------------------------------------------------------------------
// rect_outline_fill_rasterizer_top
// Byte canvas with clear, rectangle draw (outline or filled) and pixel read.
// ----------------------------------------------------------------------------
// Items enter on req (valid/ready) and each gives exactly one result beat on
// rsp: pixel_byte (read data, zero for other items) and the sticky error flag.
// Canvas size and background byte are set through cfg_we/cfg_index/cfg_data;
// the user writes them only while idle (the block does not enforce this).
// Steps per item (the canvas memory has a single write port):
//   clear: every canvas entry written once with the background byte
//   draw:  width*height in use swept, one pixel per cycle; no sweep if rejected
//   read:  address, memory read, result
// One item is worked on at a time. A result waits in the output register
// while the next item is already accepted and processed; if the receiver
// still stalls when that item finishes, the block holds it and drops ready.
// Reset clears the sticky error and pending result and loads the configuration
// reset values; the canvas holds no defined value until the first clear.
// ----------------------------------------------------------------------------
module rect_outline_fill_rasterizer_top import rorf_pkg::*; #(
  parameter int MAX_SIDE  = 256,
  parameter int FRAC_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  rorf_req_if.sink              req,
  rorf_rsp_if.source            rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int COL_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int ADDR_W = 2 * COL_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int CMP_W  = (COL_W + 1 > SIDE_W) ? COL_W + 1 : SIDE_W;
  localparam int SW     = (COL_W + FRAC_BITS + 2 > COORD_W + 1) ?
                          COL_W + FRAC_BITS + 2 : COORD_W + 1;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CLEAR  = 7'b0000010,
    S_SETUP  = 7'b0000100,
    S_PAINT  = 7'b0001000,
    S_RDADDR = 7'b0010000,
    S_RDDATA = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  // Configuration registers
  logic [SIDE_W-1:0] canvas_width;
  logic [SIDE_W-1:0] canvas_height;
  logic [PIX_W-1:0]  background_byte;

  // Item registers
  logic signed [COORD_W-1:0] left;
  logic signed [COORD_W-1:0] top;
  logic signed [COORD_W-1:0] rwidth;
  logic signed [COORD_W-1:0] rheight;
  logic                      fill_all;
  logic [PIX_W-1:0]          fill_val;
  logic [COL_W-1:0]          rd_col;
  logic [COL_W-1:0]          rd_row;
  logic                      rd_in_range;

  // Draw sweep registers
  logic signed [SW-1:0] right;
  logic signed [SW-1:0] bottom;
  logic [COL_W-1:0]     col_last;
  logic [COL_W-1:0]     row_last;
  logic [COL_W-1:0]     col_cnt;
  logic [COL_W-1:0]     row_cnt;
  logic [ADDR_W-1:0]    clr_addr;

  // Status and result
  logic             sticky_error;
  logic [PIX_W-1:0] res_pix;
  logic             out_valid;
  logic [PIX_W-1:0] out_pix;
  logic             out_err;

  // Combinational helpers
  logic [CMP_W-1:0] cols_in_use;
  logic [CMP_W-1:0] rows_in_use;
  logic             req_fire;
  logic             out_free;
  logic             bad_size;
  logic             paint_hit;
  logic             sweep_end;
  logic             mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [PIX_W-1:0] mem_wdata;
  logic             mem_re;
  logic [PIX_W-1:0] mem_rdata;

  // Clamp the size registers to 1..MAX_SIDE
  always_comb begin
    cols_in_use = CMP_W'(canvas_width);
    rows_in_use = CMP_W'(canvas_height);
    if (canvas_width == '0) begin
      cols_in_use = CMP_W'(1);
    end else if (CMP_W'(canvas_width) > CMP_W'(MAX_SIDE)) begin
      cols_in_use = CMP_W'(MAX_SIDE);
    end
    if (canvas_height == '0) begin
      rows_in_use = CMP_W'(1);
    end else if (CMP_W'(canvas_height) > CMP_W'(MAX_SIDE)) begin
      rows_in_use = CMP_W'(MAX_SIDE);
    end
  end

  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;
  assign bad_size  = (req.rect_width <= 0) || (req.rect_height <= 0);
  assign sweep_end = (col_cnt == col_last) && (row_cnt == row_last);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width    <= SIDE_RESET;
      canvas_height   <= SIDE_RESET;
      background_byte <= BG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CANVAS_WIDTH:  canvas_width    <= cfg_data;
        REG_CANVAS_HEIGHT: canvas_height   <= cfg_data;
        REG_BACKGROUND:    background_byte <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_fire) begin
          unique case (op_t'(req.op))
            OP_CLEAR: state_next = S_CLEAR;
            OP_DRAW:  state_next = (sticky_error || bad_size) ? S_DONE : S_SETUP;
            OP_READ:  state_next = S_RDADDR;
            default:  state_next = S_DONE;
          endcase
        end
      end
      S_CLEAR:  if (clr_addr == '1) state_next = S_DONE;
      S_SETUP:  state_next = S_PAINT;
      S_PAINT:  if (sweep_end) state_next = S_DONE;
      S_RDADDR: state_next = S_RDDATA;
      S_RDDATA: state_next = S_DONE;
      S_DONE:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sticky error: cleared by a clear, set by a rejected draw
  always_ff @(posedge clk) begin
    if (rst) begin
      sticky_error <= 1'b0;
    end else if (req_fire) begin
      if (op_t'(req.op) == OP_CLEAR) begin
        sticky_error <= 1'b0;
      end else if (op_t'(req.op) == OP_DRAW && bad_size) begin
        sticky_error <= 1'b1;
      end
    end
  end

  // Capture the item and run the sweeps
  always_ff @(posedge clk) begin
    if (req_fire) begin
      left        <= req.rect_left;
      top         <= req.rect_top;
      rwidth      <= req.rect_width;
      rheight     <= req.rect_height;
      fill_all    <= req.filled;
      fill_val    <= req.fill_byte;
      rd_col      <= COL_W'(req.read_col);
      rd_row      <= COL_W'(req.read_row);
      rd_in_range <= (CMP_W'(req.read_col) < cols_in_use) &&
                     (CMP_W'(req.read_row) < rows_in_use);
      res_pix     <= '0;
      clr_addr    <= '0;
    end
    if (state == S_CLEAR) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
    // Fix the far edges and sweep bounds
    if (state == S_SETUP) begin
      right    <= SW'(left) + SW'(rwidth);
      bottom   <= SW'(top) + SW'(rheight);
      col_last <= COL_W'(cols_in_use - CMP_W'(1));
      row_last <= COL_W'(rows_in_use - CMP_W'(1));
      col_cnt  <= '0;
      row_cnt  <= '0;
    end
    // Advance raster order: column first, then row
    if (state == S_PAINT) begin
      if (col_cnt == col_last) begin
        col_cnt <= '0;
        row_cnt <= row_cnt + COL_W'(1);
      end else begin
        col_cnt <= col_cnt + COL_W'(1);
      end
    end
    if (state == S_RDDATA) begin
      res_pix <= rd_in_range ? mem_rdata : '0;
    end
  end

  // Pixel coverage test
  rorf_span #(
    .COL_W     (COL_W),
    .FRAC_BITS (FRAC_BITS),
    .SW        (SW)
  ) u_span (
    .col    (col_cnt),
    .row    (row_cnt),
    .left   (SW'(left)),
    .right  (right),
    .top    (SW'(top)),
    .bottom (bottom),
    .filled (fill_all),
    .hit    (paint_hit)
  );

  // Canvas memory ports
  assign mem_we    = (state == S_CLEAR) || ((state == S_PAINT) && paint_hit);
  assign mem_waddr = (state == S_CLEAR) ? clr_addr : {row_cnt, col_cnt};
  assign mem_wdata = (state == S_CLEAR) ? background_byte : fill_val;
  assign mem_re    = (state == S_RDADDR);

  rorf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_canvas (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr ({rd_row, rd_col}),
    .rdata (mem_rdata)
  );

  // Output register: load on finish, drop on beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_pix <= res_pix;
      out_err <= sticky_error;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.pixel_byte = out_pix;
  assign rsp.error_flag = out_err;

endmodule

// ===== hdl/rorf_checker.sv =====
// ----------------------------------------------------------------------------
// rorf_checker
// Port-level checks of the rasterizer: reset, result hold, item accounting.
// ----------------------------------------------------------------------------
module rorf_checker import rorf_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input logic [PIX_W-1:0] rsp_pixel_byte,
  input logic             rsp_error_flag
);

  logic [1:0] pending;

  // Count items accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
    end else begin
      pending <= pending + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_byte) &&
    $stable(rsp_error_flag))
    else $error("stalled result changed");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 2'd0)
    else $error("result without an accepted item");

  a_two_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> pending != 2'd2 && pending != 2'd3)
    else $error("ready while two items are outstanding");

endmodule

bind rect_outline_fill_rasterizer_top rorf_checker u_rorf_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_pixel_byte (rsp.pixel_byte),
  .rsp_error_flag (rsp.error_flag)
);
